// ===== hdl/pssg_pkg.sv =====
// -----------------------------------------------------------------------------
// pssg_pkg
// Shared types and constants of the pulse/sawtooth sound generator.
// -----------------------------------------------------------------------------
package pssg_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int PERIOD_W          = 12;
   localparam int DEFICIT_W         = 24;   // width of cycles_per_sample
   localparam int CSR_INDEX_W       = 1;

   localparam logic [DEFICIT_W-1:0] CPS_RESET = 24'd2659767;

   // item kinds
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // voices
   localparam logic [1:0] CH_PULSE_A = 2'd0;
   localparam logic [1:0] CH_PULSE_B = 2'd1;
   localparam logic [1:0] CH_SAW     = 2'd2;
   localparam logic [1:0] CH_NONE    = 2'd3;

   // registers within a voice
   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_CTRL      = 2'd1;
   localparam logic [1:0] REG_PERIOD_LO = 2'd2;

   // configuration registers
   localparam logic [CSR_INDEX_W-1:0] CSR_CPS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MUTE = 1'b1;

   typedef enum logic [2:0] {
      CMD_IDLE,
      CMD_WRITE,
      CMD_START,
      CMD_DIV,
      CMD_FINISH,
      CMD_RESULT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [1:0] sel;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic rsp_free;
   } status_type;

endpackage

// ===== hdl/pssg_ctrl.sv =====
// -----------------------------------------------------------------------------
// pssg_ctrl
// Sequencer: takes items, walks the three voices through phase update and
// step division, then loads the result register.
// -----------------------------------------------------------------------------
module pssg_ctrl import pssg_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_op,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_FINISH,
      ST_RESULT
   } state_type;

   localparam int CNT_W = $clog2(DEFICIT_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DEFICIT_W - 1);

   state_type        state_ff, state_in;
   logic [1:0]       sel_ff, sel_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      cnt_in   = cnt_ff;
      cmd.op   = CMD_IDLE;
      cmd.sel  = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_op == OP_TICK) begin
                  state_in = ST_START;
                  sel_in   = CH_PULSE_A;
               end else begin
                  cmd.op = CMD_WRITE;
               end
            end
         end
         ST_START: begin
            cmd.op = CMD_START;
            cnt_in = '0;
            state_in = status.need_div ? ST_DIV : ST_FINISH;
         end
         ST_DIV: begin
            cmd.op = CMD_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.op = CMD_FINISH;
            if (sel_ff == CH_SAW) begin
               state_in = ST_RESULT;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_START;
            end
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (status.rsp_free) begin
               cmd.op   = CMD_RESULT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= CH_PULSE_A;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hdl/pssg_datapath.sv =====
// -----------------------------------------------------------------------------
// pssg_datapath
// Voice registers, phase counters, shared step divider, step/accumulator
// update, level mixing and the result register.
// -----------------------------------------------------------------------------
module pssg_datapath import pssg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DEFICIT_W-1:0]   csr_data,
   input  logic [1:0]             req_channel,
   input  logic [1:0]             req_reg_index,
   input  logic [7:0]             req_reg_value,
   input  logic                   rsp_tready,
   output logic                   rsp_valid,
   output logic [5:0]             rsp_mix,
   output logic [3:0]             rsp_pulse_a_level,
   output logic [3:0]             rsp_pulse_b_level,
   output logic [4:0]             rsp_saw_level
);

   localparam int PW = PERIOD_W + FRAC_BITS;                       // phase width
   localparam int EW = (PW > DEFICIT_W) ? PW : DEFICIT_W;           // phase compare
   localparam int CW = (PW > DEFICIT_W + 1) ? PW : DEFICIT_W + 1;   // divider compare
   localparam int NW = DEFICIT_W + 1;                               // step count

   // configuration
   logic [DEFICIT_W-1:0] cps_ff, cps_in;
   logic [2:0]           mute_ff, mute_in;
   // voice registers
   logic [7:0]           mode_ff[3], mode_in[3];
   logic [7:0]           ctl_ff[3], ctl_in[3];
   logic [7:0]           lo_ff[3], lo_in[3];
   // voice state
   logic [PW-1:0]        phase_ff[3], phase_in[3];
   logic [3:0]           pstep_ff[2], pstep_in[2];
   logic [2:0]           sstep_ff, sstep_in;
   logic [8:0]           acc_ff, acc_in;
   // divider
   logic [DEFICIT_W-1:0] dvd_ff, dvd_in;
   logic [DEFICIT_W-1:0] rem_ff, rem_in;
   logic [DEFICIT_W-1:0] quo_ff, quo_in;
   logic [2:0]           qm7_ff, qm7_in;
   logic                 div_ff, div_in;
   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [5:0]           mix_ff, mix_in;
   logic [3:0]           la_ff, la_in, lb_ff, lb_in;
   logic [4:0]           ls_ff, ls_in;

   // selected voice
   logic [PERIOD_W-1:0]  period;
   logic [PW-1:0]        spd;
   logic                 live;
   logic [PW-1:0]        cnt;
   logic                 cnt_ge;
   logic [DEFICIT_W-1:0] deficit;
   logic [PW-1:0]        cnt_sub;
   // divider step
   logic [DEFICIT_W:0]   trial;
   logic                 tr_ge;
   logic [CW-1:0]        tr_diff;
   logic [3:0]           qm_sum;
   // finish
   logic                 rem_nz;
   logic [NW-1:0]        n;
   logic [3:0]           nm7_sum;
   logic [2:0]           nm7;
   logic [PW-1:0]        cnt_fin;
   logic [5:0]           rate;
   logic [2:0]           room;
   logic                 short_run;
   logic [8:0]           prod_short;
   logic [3:0]           wrap_sum;
   logic [2:0]           step_wrap;
   logic [8:0]           prod_wrap;
   // levels
   logic [PERIOD_W-1:0]  period_v[3];
   logic [3:0]           lvl_p[2];
   logic [4:0]           lvl_s;

   always_comb begin
      period  = {ctl_ff[cmd.sel][3:0], lo_ff[cmd.sel]};
      spd     = PW'(period) << FRAC_BITS;
      live    = (period != '0);
      cnt     = phase_ff[cmd.sel];
      cnt_ge  = EW'(cnt) >= EW'(cps_ff);
      deficit = DEFICIT_W'(EW'(cps_ff) - EW'(cnt));
      cnt_sub = PW'(EW'(cnt) - EW'(cps_ff));

      // restoring division, one quotient bit a cycle; quotient mod 7 kept alongside
      trial   = {rem_ff, dvd_ff[DEFICIT_W-1]};
      tr_ge   = CW'(trial) >= CW'(spd);
      tr_diff = CW'(trial) - CW'(spd);
      qm_sum  = {qm7_ff, tr_ge};

      // steps = ceil(deficit / spd)
      rem_nz  = (rem_ff != '0);
      n       = NW'(quo_ff) + NW'(rem_nz);
      nm7_sum = {1'b0, qm7_ff} + {3'b000, rem_nz};
      nm7     = (nm7_sum == 4'd7) ? 3'd0 : nm7_sum[2:0];
      cnt_fin = rem_nz ? PW'(CW'(spd) - CW'(rem_ff)) : '0;

      rate       = mode_ff[CH_SAW][5:0];
      room       = 3'd7 - sstep_ff;
      short_run  = n < NW'(room);
      prod_short = 9'(n[2:0]) * 9'(rate);
      wrap_sum   = {1'b0, sstep_ff} + {1'b0, nm7};
      step_wrap  = (wrap_sum >= 4'd7) ? 3'(wrap_sum - 4'd7) : wrap_sum[2:0];
      prod_wrap  = 9'(step_wrap) * 9'(rate);
   end

   // levels from the state left by the finished tick
   always_comb begin
      for (int v = 0; v < 3; v++) begin
         period_v[v] = {ctl_ff[v][3:0], lo_ff[v]};
      end
      for (int v = 0; v < 2; v++) begin
         lvl_p[v] = '0;
         if ((period_v[v] != '0) && !mute_ff[v] && ctl_ff[v][7] &&
             (mode_ff[v][7] || (pstep_ff[v] > {1'b0, mode_ff[v][6:4]}))) begin
            lvl_p[v] = mode_ff[v][3:0];
         end
      end
      lvl_s = '0;
      if ((period_v[CH_SAW] != '0) && !mute_ff[CH_SAW] && ctl_ff[CH_SAW][7]) begin
         lvl_s = acc_ff[7:3];
      end
   end

   always_comb begin
      cps_in       = cps_ff;
      mute_in      = mute_ff;
      mode_in      = mode_ff;
      ctl_in       = ctl_ff;
      lo_in        = lo_ff;
      phase_in     = phase_ff;
      pstep_in     = pstep_ff;
      sstep_in     = sstep_ff;
      acc_in       = acc_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      qm7_in       = qm7_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mix_in       = mix_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      ls_in        = ls_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_CPS:  cps_in  = csr_data;
            CSR_MUTE: mute_in = csr_data[2:0];
            default:  ;
         endcase
      end

      unique case (cmd.op)
         CMD_WRITE: begin
            if (req_channel != CH_NONE) begin
               unique case (req_reg_index)
                  REG_MODE:      mode_in[req_channel] = req_reg_value;
                  REG_CTRL:      ctl_in[req_channel]  = req_reg_value;
                  REG_PERIOD_LO: lo_in[req_channel]   = req_reg_value;
                  default:       ;   // spare register, no effect
               endcase
            end
         end
         CMD_START: begin
            div_in = live && !cnt_ge;
            dvd_in = deficit;
            rem_in = '0;
            quo_in = '0;
            qm7_in = '0;
            if (live && cnt_ge) begin
               phase_in[cmd.sel] = cnt_sub;
            end
         end
         CMD_DIV: begin
            dvd_in = dvd_ff << 1;
            rem_in = tr_ge ? DEFICIT_W'(tr_diff) : trial[DEFICIT_W-1:0];
            quo_in = {quo_ff[DEFICIT_W-2:0], tr_ge};
            qm7_in = (qm_sum >= 4'd7) ? 3'(qm_sum - 4'd7) : qm_sum[2:0];
         end
         CMD_FINISH: begin
            if (live && div_ff) begin
               phase_in[cmd.sel] = cnt_fin;
               if (cmd.sel == CH_SAW) begin
                  if (short_run) begin
                     sstep_in = sstep_ff + n[2:0];
                     acc_in   = acc_ff + prod_short;
                  end else begin
                     sstep_in = step_wrap;
                     acc_in   = prod_wrap;
                  end
               end else begin
                  pstep_in[cmd.sel[0]] = pstep_ff[cmd.sel[0]] + n[3:0];
               end
            end
         end
         CMD_RESULT: begin
            rsp_valid_in = 1'b1;
            la_in  = lvl_p[0];
            lb_in  = lvl_p[1];
            ls_in  = lvl_s;
            mix_in = 6'(lvl_p[0]) + 6'(lvl_p[1]) + 6'(lvl_s);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff       <= CPS_RESET;
         mute_ff      <= '0;
         sstep_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < 3; v++) begin
            mode_ff[v]  <= '0;
            ctl_ff[v]   <= '0;
            lo_ff[v]    <= '0;
            phase_ff[v] <= '0;
         end
         for (int v = 0; v < 2; v++) begin
            pstep_ff[v] <= '0;
         end
      end else begin
         cps_ff       <= cps_in;
         mute_ff      <= mute_in;
         mode_ff      <= mode_in;
         ctl_ff       <= ctl_in;
         lo_ff        <= lo_in;
         phase_ff     <= phase_in;
         pstep_ff     <= pstep_in;
         sstep_ff     <= sstep_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      qm7_ff <= qm7_in;
      div_ff <= div_in;
      mix_ff <= mix_in;
      la_ff  <= la_in;
      lb_ff  <= lb_in;
      ls_ff  <= ls_in;
   end

   assign status.need_div = live && !cnt_ge;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mix           = mix_ff;
   assign rsp_pulse_a_level = la_ff;
   assign rsp_pulse_b_level = lb_ff;
   assign rsp_saw_level     = ls_ff;

endmodule

// ===== hdl/pulse_saw_sound_generator.sv =====
// -----------------------------------------------------------------------------
// pulse_saw_sound_generator
// Two pulse voices and one sawtooth voice, driven by register writes and
// sample ticks; one mixed result per tick.
// -----------------------------------------------------------------------------
// A register write gives no result. A sample tick runs the three voices one
// after another through a shared restoring divider that finds how many steps
// each voice takes in the sample: per voice a setup state, the divider state
// when the phase counter underflows (skipped otherwise) and an update state,
// then a result state that loads the result register; the next item is taken
// once the tick is back in idle. The result register lets the next item in
// while a result waits; a tick then holds in its last cycle until the waiting
// result is taken. Configuration writes are accepted in every cycle.
// -----------------------------------------------------------------------------
module pulse_saw_sound_generator import pssg_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,   // channel[1:0], reg_index[3:2], reg_value[11:4]
   input  logic                   req_tuser,   // operation
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // mix[5:0], pulse_a_level[9:6],
                                               // pulse_b_level[13:10], saw_level[18:14]
   // configuration
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DEFICIT_W-1:0]   csr_data
);

   cmd_type    cmd;
   status_type status;
   logic [5:0] mix;
   logic [3:0] pulse_a_level;
   logic [3:0] pulse_b_level;
   logic [4:0] saw_level;

   assign csr_ready = 1'b1;

   pssg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   pssg_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_channel       (req_tdata[1:0]),
      .req_reg_index     (req_tdata[3:2]),
      .req_reg_value     (req_tdata[11:4]),
      .rsp_tready        (rsp_tready),
      .rsp_valid         (rsp_tvalid),
      .rsp_mix           (mix),
      .rsp_pulse_a_level (pulse_a_level),
      .rsp_pulse_b_level (pulse_b_level),
      .rsp_saw_level     (saw_level)
   );

   assign rsp_tdata = {5'b00000, saw_level, pulse_b_level, pulse_a_level, mix};

endmodule
